// ===== rtl/mdp_pkg.sv =====
// Package with shared types and constants of the mouse delta packetizer.
`timescale 1ns / 1ps
`default_nettype none

package mdp_pkg;

  localparam logic [7:0] HostPktReq  = 8'h40;
  localparam logic [7:0] HostPktPre  = 8'h41;
  localparam logic [7:0] HostKeysOff = 8'h48;
  localparam logic [7:0] HostKeysOn  = 8'h49;

  localparam logic signed [15:0] OvfHigh = 16'sd127;
  localparam logic signed [15:0] OvfLow  = -16'sd128;
  localparam logic signed [15:0] AccMax  = 16'sh7FFF;
  localparam logic signed [15:0] AccMin  = -16'sh8000;

  localparam logic [3:0] DividerReset = 4'd3;

  localparam logic OpMouse = 1'b0;
  localparam logic OpHost  = 1'b1;

  typedef struct packed {
    logic       start;
    logic [7:0] mag;
    logic [3:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mdp_div.sv =====
// Bit-serial restoring divider for an 8-bit magnitude by a 4-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module mdp_div (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire mdp_pkg::div_req_t req_i,
  output mdp_pkg::div_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  div_q, div_d;
  logic [12:0] work_q, work_d;
  logic [12:0] shifted;
  logic [4:0]  trial;

  always_comb begin
    shifted = {work_q[11:0], 1'b0};
    trial   = shifted[12:8] - {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    div_d   = div_q;
    work_d  = work_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      div_d  = (req_i.divisor == 4'd0) ? 4'd1 : req_i.divisor;
      work_d = {5'd0, req_i.mag};
    end else if (busy_q) begin
      if (shifted[12:8] >= {1'b0, div_q}) begin
        work_d = {trial, shifted[7:1], 1'b1};
      end else begin
        work_d = shifted;
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    work_q <= work_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q[7:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("Divider reports done while still busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 3'd7) |=> done_q)
    else $error("Divider missed its done pulse after the last step.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> div_q != 4'd0)
    else $error("Divider runs with a zero divisor.");

endmodule

`default_nettype wire

// ===== rtl/mouse_delta_packetizer.sv =====
// Top level of the mouse delta packetizer: sequencer, accumulators and output word register.
// A report runs two divides (X then Y) on the shared divider, each of eight steps and then its
// done pulse, then the emit state; no new item is taken until the sequencer is idle again.
// A host byte goes straight to the emit state, and a packet gives one word per cycle while the
// output is not stalled; a stalled output word holds back the emit state.
// Reset is asynchronous and active low: accumulators, buttons, previous host byte and
// keyboard enable clear, the divider register returns to 3 and no word is pending.
`timescale 1ns / 1ps
`default_nettype none

module mouse_delta_packetizer (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [3:0]       cfg_wdata_i,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire              operation_i,
  input  wire signed [7:0] move_x_i,
  input  wire signed [7:0] move_y_i,
  input  wire              left_button_i,
  input  wire              right_button_i,
  input  wire  [7:0]       host_byte_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [7:0]       mouse_byte_o,
  output logic             byte_valid_o,
  output logic             last_of_run_o,
  output logic             keys_enabled_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [3:0]         divider_q;
  logic signed [15:0] acc_x_q;
  logic signed [15:0] acc_y_q;
  logic               left_q;
  logic               right_q;
  logic [7:0]         prev_host_q;
  logic               keys_q;
  logic signed [7:0]  hold_y_q;
  logic               neg_q;
  logic               pkt_q;
  logic [1:0]         idx_q;
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_bvalid_q;
  logic               out_last_q;
  logic               out_keys_q;

  mdp_pkg::div_req_t div_req;
  mdp_pkg::div_rsp_t div_rsp;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic signed [8:0]  delta;
  logic signed [15:0] add_acc;
  logic signed [16:0] sum;
  logic signed [15:0] sat_sum;
  logic [7:0]         status;
  logic [7:0]         emit_byte;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == S_EMIT) && out_free;

  always_comb begin
    div_req.start   = 1'b0;
    div_req.mag     = 8'd0;
    div_req.divisor = divider_q;
    if (accept && operation_i == mdp_pkg::OpMouse) begin
      div_req.start = 1'b1;
      div_req.mag   = move_x_i[7] ? 8'(-move_x_i) : move_x_i;
    end else if (state_q == S_DIV_X && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.mag   = hold_y_q[7] ? 8'(-hold_y_q) : hold_y_q;
    end
  end

  mdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    delta   = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    add_acc = (state_q == S_DIV_Y) ? acc_y_q : acc_x_q;
    sum     = {add_acc[15], add_acc} + {{8{delta[8]}}, delta};
    if (sum[16] != sum[15]) begin
      sat_sum = sum[16] ? mdp_pkg::AccMin : mdp_pkg::AccMax;
    end else begin
      sat_sum = sum[15:0];
    end
  end

  always_comb begin
    status = {acc_y_q < mdp_pkg::OvfLow, acc_y_q > mdp_pkg::OvfHigh,
              acc_x_q < mdp_pkg::OvfLow, acc_x_q > mdp_pkg::OvfHigh,
              2'b00, right_q, left_q};
    case (idx_q)
      2'd0:    emit_byte = status;
      2'd1:    emit_byte = acc_x_q[7:0];
      default: emit_byte = acc_y_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      divider_q    <= mdp_pkg::DividerReset;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      prev_host_q  <= 8'd0;
      keys_q       <= 1'b0;
      hold_y_q     <= '0;
      neg_q        <= 1'b0;
      pkt_q        <= 1'b0;
      idx_q        <= 2'd0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= 8'd0;
      out_bvalid_q <= 1'b0;
      out_last_q   <= 1'b0;
      out_keys_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        divider_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= 2'd0;
            if (operation_i == mdp_pkg::OpMouse) begin
              hold_y_q <= move_y_i;
              neg_q    <= move_x_i[7];
              left_q   <= left_button_i;
              right_q  <= right_button_i;
              pkt_q    <= 1'b0;
              state_q  <= S_DIV_X;
            end else begin
              prev_host_q <= host_byte_i;
              pkt_q <= (host_byte_i == mdp_pkg::HostPktReq) &&
                       (prev_host_q == mdp_pkg::HostPktPre);
              if (host_byte_i == mdp_pkg::HostKeysOff) begin
                keys_q <= 1'b0;
              end else if (host_byte_i == mdp_pkg::HostKeysOn) begin
                keys_q <= 1'b1;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            acc_x_q <= sat_sum;
            neg_q   <= hold_y_q[7];
            state_q <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            acc_y_q <= sat_sum;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_keys_q   <= keys_q;
            out_bvalid_q <= pkt_q;
            out_byte_q   <= pkt_q ? emit_byte : 8'd0;
            out_last_q   <= !pkt_q || (idx_q == 2'd2);
            idx_q        <= idx_q + 2'd1;
            if (!pkt_q || idx_q == 2'd2) begin
              state_q <= S_IDLE;
              if (pkt_q) begin
                acc_x_q <= '0;
                acc_y_q <= '0;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign mouse_byte_o   = out_byte_q;
  assign byte_valid_o   = out_bvalid_q;
  assign last_of_run_o  = out_last_q;
  assign keys_enabled_o = out_keys_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_X || state_q == S_DIV_Y))
    else $error("Divider finished outside a divide step.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_rsp.busy |-> in_stall_o)
    else $error("Input taken while the divider is busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && pkt_q && idx_q == 2'd2) |=>
    (acc_x_q == 16'sd0 && acc_y_q == 16'sd0))
    else $error("Accumulators not cleared after the packet.");

endmodule

`default_nettype wire
